// ===== rtl/mrs_pkg.sv =====
package mrs_pkg;

  localparam int CHANNELS = 32;
  localparam int CH_W     = $clog2(CHANNELS);

  localparam logic signed [31:0] MIN_RESET = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MAX_RESET = 32'sh8000_0000;

  typedef struct packed {
    logic        [4:0]  channel;
    logic signed [31:0] sample_value;
    logic               new_record;
  } mrs_in_t;

  typedef struct packed {
    logic signed [47:0] total;
    logic signed [31:0] mean;
    logic        [31:0] std_dev;
    logic signed [31:0] minimum;
    logic signed [31:0] maximum;
    logic        [31:0] sample_count;
    logic        [31:0] record_count;
  } mrs_out_t;

  typedef struct packed {
    logic        [31:0] samples;
    logic signed [47:0] sum;
    logic        [63:0] sumsq;
    logic signed [31:0] mn;
    logic signed [31:0] mx;
  } mrs_stat_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic write;
    logic div_mean_go;
    logic take_mean;
    logic div_e_go;
    logic take_e;
    logic mul;
    logic sqrt_go;
    logic take_sd;
    logic load_out;
  } mrs_cmd_t;

  typedef struct packed {
    logic no_samples;
    logic div_done;
    logic sqrt_done;
  } mrs_sts_t;

endpackage

// ===== rtl/mrs_div.sv =====
module mrs_div import mrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] sh;

  always_comb begin
    sh = {rem_r, dvd_r[63]};
    if (sh >= {1'b0, dvs_r}) begin
      rem_nxt = 32'(sh - {1'b0, dvs_r});
      dvd_nxt = {dvd_r[62:0], 1'b1};
    end else begin
      rem_nxt = sh[31:0];
      dvd_nxt = {dvd_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

// ===== rtl/mrs_sqrt.sv =====
module mrs_sqrt import mrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] v_r, res_r, bit_r;
  logic [63:0] trial;
  logic        busy_r;
  logic        done_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res_r[31:0];
  assign done = done_r;

endmodule

// ===== rtl/mrs_datapath.sv =====
module mrs_datapath import mrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mrs_in_t  in_data,
  input  mrs_cmd_t cmd,
  output mrs_sts_t sts,
  output mrs_out_t out_data
);

  mrs_stat_t         mem [CHANNELS];
  logic              vld_r [CHANNELS];
  mrs_in_t           in_r;
  mrs_stat_t         rd_r;
  logic              rdv_r;
  mrs_stat_t         st_r;
  logic [63:0]       sq_r;
  logic [31:0]       records_r;
  logic signed [31:0] mean_r;
  logic [63:0]       e_r;
  logic [63:0]       m2_r;
  logic [31:0]       sd_r;
  mrs_out_t          out_r;

  logic [CH_W-1:0]   idx;
  logic              chan_ok;
  mrs_stat_t         cur;
  mrs_stat_t         upd;
  logic signed [31:0] x;
  logic [31:0]       ax;
  logic signed [48:0] s49;
  logic [64:0]       sq65;
  logic [63:0]       sumsq_new;
  logic [47:0]       mag;
  logic [63:0]       div_q;
  logic              div_done;
  logic signed [31:0] mean_new;
  logic [31:0]       am;
  logic [63:0]       div_dvd;
  logic [31:0]       sd_root;
  logic              sqrt_done;

  assign idx     = CH_W'(in_r.channel);
  assign chan_ok = ({2'b0, in_r.channel} < 7'(CHANNELS));
  assign x       = in_r.sample_value;
  assign ax      = x[31] ? 32'(-x) : 32'(x);

  always_comb begin
    if (rdv_r) begin
      cur = rd_r;
    end else begin
      cur = '{samples: '0, sum: '0, sumsq: '0, mn: MIN_RESET, mx: MAX_RESET};
    end
    upd = cur;
    s49 = 49'(cur.sum) + 49'(x);
    if (chan_ok && x != 32'sd0) begin
      if (cur.samples != 32'hFFFF_FFFF) begin
        upd.samples = cur.samples + 32'd1;
      end
      if (s49[48] != s49[47]) begin
        upd.sum = s49[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      end else begin
        upd.sum = s49[47:0];
      end
      if (x < cur.mn) begin
        upd.mn = x;
      end
      if (x > cur.mx) begin
        upd.mx = x;
      end
    end
  end

  assign sq65      = {1'b0, st_r.sumsq} + {1'b0, sq_r};
  assign sumsq_new = sq65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq65[63:0];

  assign mag     = st_r.sum[47] ? 48'(-st_r.sum) : 48'(st_r.sum);
  assign div_dvd = cmd.div_e_go ? st_r.sumsq : {16'd0, mag};

  always_comb begin
    if (st_r.sum[47]) begin
      mean_new = (div_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_q[31:0]);
    end else begin
      mean_new = (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
    end
  end

  assign am = mean_r[31] ? 32'(-mean_r) : 32'(mean_r);

  mrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_mean_go | cmd.div_e_go),
    .dividend (div_dvd),
    .divisor  (st_r.samples),
    .quotient (div_q),
    .done     (div_done)
  );

  mrs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_go),
    .radicand ((e_r > m2_r) ? (e_r - m2_r) : 64'd0),
    .root     (sd_root),
    .done     (sqrt_done)
  );

  // channel store
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_r <= mem[idx];
    end
    if (cmd.write && chan_ok) begin
      mem[idx] <= '{samples: st_r.samples, sum: st_r.sum, sumsq: sumsq_new,
                    mn: st_r.mn, mx: st_r.mx};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        vld_r[i] <= 1'b0;
      end
      records_r <= '0;
      rdv_r     <= 1'b0;
    end else begin
      if (cmd.write && chan_ok) begin
        vld_r[idx] <= 1'b1;
      end
      if (cmd.read) begin
        rdv_r <= vld_r[idx] && chan_ok;
      end
      if (cmd.capture && in_data.new_record && records_r != 32'hFFFF_FFFF) begin
        records_r <= records_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.update) begin
      st_r <= upd;
      sq_r <= (chan_ok && x != 32'sd0) ? ax * ax : 64'd0;
    end
    if (cmd.write) begin
      st_r.sumsq <= sumsq_new;
    end
    if (cmd.take_mean) begin
      mean_r <= mean_new;
    end
    if (cmd.take_e) begin
      e_r <= div_q;
    end
    if (cmd.mul) begin
      m2_r <= am * am;
    end
    if (cmd.take_sd) begin
      sd_r <= sd_root;
    end
    if (cmd.load_out) begin
      out_r.total        <= st_r.sum;
      out_r.mean         <= sts.no_samples ? 32'sd0 : mean_r;
      out_r.std_dev      <= sts.no_samples ? 32'd0 : sd_r;
      out_r.minimum      <= st_r.mn;
      out_r.maximum      <= st_r.mx;
      out_r.sample_count <= st_r.samples;
      out_r.record_count <= records_r;
    end
  end

  assign sts.no_samples = (st_r.samples == 32'd0);
  assign sts.div_done   = div_done;
  assign sts.sqrt_done  = sqrt_done;
  assign out_data       = out_r;

endmodule

// ===== rtl/mrs_ctrl.sv =====
module mrs_ctrl import mrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  mrs_sts_t sts,
  output mrs_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_UPDATE, S_WRITE, S_DIV_M, S_WAIT_M, S_DIV_E, S_WAIT_E,
    S_MUL, S_SQRT, S_WAIT_S, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = sts.no_samples ? S_OUT : S_DIV_M;
      end
      S_DIV_M: begin
        cmd.div_mean_go = 1'b1;
        state_nxt       = S_WAIT_M;
      end
      S_WAIT_M: begin
        if (sts.div_done) begin
          cmd.take_mean = 1'b1;
          state_nxt     = S_DIV_E;
        end
      end
      S_DIV_E: begin
        cmd.div_e_go = 1'b1;
        state_nxt    = S_WAIT_E;
      end
      S_WAIT_E: begin
        if (sts.div_done) begin
          cmd.take_e = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = S_WAIT_S;
      end
      S_WAIT_S: begin
        if (sts.sqrt_done) begin
          cmd.take_sd = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.load_out)
    else $error("result register overwritten while stalled");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_WAIT_M || state_r == S_WAIT_E))
    else $error("divider finished outside a wait state");

endmodule

// ===== rtl/multichannel_running_statistics.sv =====
// channel  ports                             direction
// in       in_valid in_stall in_data         transaction in
// out      out_valid out_stall out_data      transaction out
//
// an item with no samples on its channel goes from the write state straight to the output state
// otherwise the shared restoring divider makes two passes (mean, then mean square)
// and a square root of their difference follows before the result is loaded
// reset is synchronous, active low; per-channel valid bits clear the statistics at once
// a finished result waits in the output register while out_stall is high
module multichannel_running_statistics import mrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mrs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mrs_out_t out_data
);

  mrs_cmd_t cmd;
  mrs_sts_t sts;

  mrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrs_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
